// File: rtl/periodic_task_tick_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: assertion macros
// Concurrent assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PTTS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptts: assertion failed");

// Next-cycle implication.
`define PTTS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptts: assertion failed");

`endif

// File: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: package
// Widths, register indexes, opcodes and the types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   localparam int MAX_TASKS_DEFAULT = 8;

   localparam int TIME_W  = 16;
   localparam int PER_W   = 12;
   localparam int BUR_W   = 12;
   localparam int REL_W   = 18;
   localparam int RCNT_W  = 8;
   localparam int TCNT_W  = 4;
   localparam int SLOT_W  = 3;
   localparam int RMISS_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RELEASES = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic             POLICY_EDF = 1'b0;
   localparam logic             POLICY_RM  = 1'b1;
   localparam logic [TCNT_W-1:0] TASK_COUNT_RESET   = 4'd8;
   localparam logic [RCNT_W-1:0] MAX_RELEASES_RESET = 8'd5;

   typedef struct packed {
      logic              policy_mode;
      logic [TCNT_W-1:0] task_count;
      logic [RCNT_W-1:0] max_releases;
   } ptts_cfg_type;

   typedef struct packed {
      logic capture;
      logic scan_clear;
      logic load_write;
      logic scan_read;
      logic finish;
   } ptts_cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic no_slots;
      logic scan_last;
   } ptts_status_type;

   typedef struct packed {
      logic [PER_W-1:0]  period;
      logic [BUR_W-1:0]  burst;
      logic [REL_W-1:0]  rel_time;
      logic [REL_W-1:0]  due_time;
      logic [BUR_W-1:0]  work;
      logic [RCNT_W-1:0] count;
   } ptts_row_type;

endpackage

`default_nettype wire

// File: rtl/periodic_task_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler unit
// Usage:
//   A request beat is taken when start is high and busy is low. Opcode load
//   writes one task slot and gives no result; busy is high for one cycle.
//   Opcode tick releases the due slots, runs one unit of the ready slot with
//   the smallest key (deadline or period, chosen by policy_mode) and gives
//   one result beat.
//   A tick scans the n taking-part slots one per cycle through the slot
//   memory's single read port; busy stays high through the scan, a drain
//   state and a finish state, and the result beat, registered from the
//   finish state, shows rsp_valid high for one cycle (busy is high for one
//   cycle, in the finish state alone, when n is zero). A new request is
//   taken only after busy falls again.
//   The receiver cannot stall: each result beat is present for exactly one
//   cycle. Configuration beats on the csr_ channel are always ready and must be
//   written only while the block is idle; the block itself does not enforce this.
//   Synchronous reset returns the controller to idle, clears time, counters
//   and the slot written flags, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic                 req_opcode,
   input  wire logic [SLOT_W-1:0]    req_task_index,
   input  wire logic [TIME_W-1:0]    req_task_arrival,
   input  wire logic [PER_W-1:0]     req_task_period,
   input  wire logic [BUR_W-1:0]     req_task_burst,
   output      logic                 rsp_valid,
   output      logic [TIME_W-1:0]    rsp_tick_time,
   output      logic                 rsp_cpu_idle,
   output      logic [SLOT_W-1:0]    rsp_running_task,
   output      logic [RMISS_W-1:0]   rsp_release_misses,
   output      logic                 rsp_finish_miss,
   output      logic [TIME_W-1:0]    rsp_miss_total,
   output      logic [TIME_W-1:0]    rsp_busy_ticks,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   ptts_cfg_type    cfg;
   ptts_cmd_type    cmd;
   ptts_status_type status;

   ptts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ptts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ptts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .req_opcode         (req_opcode),
      .req_task_index     (req_task_index),
      .req_task_arrival   (req_task_arrival),
      .req_task_period    (req_task_period),
      .req_task_burst     (req_task_burst),
      .rsp_valid          (rsp_valid),
      .rsp_tick_time      (rsp_tick_time),
      .rsp_cpu_idle       (rsp_cpu_idle),
      .rsp_running_task   (rsp_running_task),
      .rsp_release_misses (rsp_release_misses),
      .rsp_finish_miss    (rsp_finish_miss),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_busy_ticks     (rsp_busy_ticks)
   );

endmodule

`default_nettype wire

// File: rtl/ptts_csr.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: configuration registers
// Holds the policy, the number of taking-part slots and the release limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_csr import ptts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output      ptts_cfg_type         cfg
);

   ptts_cfg_type cfg_ff;
   ptts_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_POLICY_MODE:  cfg_in.policy_mode  = csr_data[0];
            CSR_TASK_COUNT:   cfg_in.task_count   = csr_data[TCNT_W-1:0];
            CSR_MAX_RELEASES: cfg_in.max_releases = csr_data[RCNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy_mode  <= POLICY_EDF;
         cfg_ff.task_count   <= TASK_COUNT_RESET;
         cfg_ff.max_releases <= MAX_RELEASES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: controller
// Sequences a load, or a tick's slot scan and its finishing step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_tick_scheduler_unit_defines.svh"

module ptts_ctrl import ptts_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output      logic            busy,
   input  wire ptts_status_type status,
   output      ptts_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } ptts_state_type;

   ptts_state_type state_ff;
   ptts_state_type state_in;
   logic           accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!status.req_is_tick) begin
                  state_in = ST_LOAD;
               end else if (status.no_slots) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.capture    = accept;
      cmd.scan_clear = accept;
      cmd.load_write = (state_ff == ST_LOAD);
      cmd.scan_read  = (state_ff == ST_SCAN);
      cmd.finish     = (state_ff == ST_FINISH);
   end

   `PTTS_ASSERT_NXT(a_finish_to_idle, clock, reset, state_ff == ST_FINISH, state_ff == ST_IDLE)
   `PTTS_ASSERT_NXT(a_load_to_idle, clock, reset, state_ff == ST_LOAD, state_ff == ST_IDLE)
   `PTTS_ASSERT_NXT(a_empty_tick, clock, reset, accept && status.req_is_tick && status.no_slots, state_ff == ST_FINISH)
   `PTTS_ASSERT_NXT(a_scan_end, clock, reset, state_ff == ST_SCAN && status.scan_last, state_ff == ST_DRAIN)

endmodule

`default_nettype wire

// File: rtl/ptts_datapath.sv
// ----------------------------------------------------------------------------
// Periodic task tick scheduler: datapath
// Task slot memory, release and selection over one slot a cycle, counters
// and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_datapath import ptts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ptts_cmd_type       cmd,
   output      ptts_status_type    status,
   input  wire ptts_cfg_type       cfg,
   input  wire logic               req_opcode,
   input  wire logic [SLOT_W-1:0]  req_task_index,
   input  wire logic [TIME_W-1:0]  req_task_arrival,
   input  wire logic [PER_W-1:0]   req_task_period,
   input  wire logic [BUR_W-1:0]   req_task_burst,
   output      logic               rsp_valid,
   output      logic [TIME_W-1:0]  rsp_tick_time,
   output      logic               rsp_cpu_idle,
   output      logic [SLOT_W-1:0]  rsp_running_task,
   output      logic [RMISS_W-1:0] rsp_release_misses,
   output      logic               rsp_finish_miss,
   output      logic [TIME_W-1:0]  rsp_miss_total,
   output      logic [TIME_W-1:0]  rsp_busy_ticks
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int LIM_W = (CNT_W > TCNT_W) ? CNT_W : TCNT_W;

   // Request capture.
   logic [SLOT_W-1:0] req_index_ff;
   logic [TIME_W-1:0] req_arrival_ff;
   logic [PER_W-1:0]  req_period_ff;
   logic [BUR_W-1:0]  req_burst_ff;

   // Slot memory and per-slot written flags.
   ptts_row_type     mem_ff [MAX_TASKS];
   logic [MAX_TASKS-1:0] valid_ff;

   // Scan pipeline.
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] eval_idx_ff;
   logic             rd_fire_ff;
   logic             rd_valid_ff;
   ptts_row_type     rd_row_ff;

   // Selection and tick state.
   logic               found_ff;
   logic [REL_W-1:0]   best_key_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   ptts_row_type       best_row_ff;
   logic [CNT_W-1:0]   rel_miss_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [TIME_W-1:0]  miss_ff;
   logic [TIME_W-1:0]  busy_ff;

   // Result registers.
   logic               rsp_valid_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic               rsp_idle_ff;
   logic [SLOT_W-1:0]  rsp_task_ff;
   logic [RMISS_W-1:0] rsp_rmiss_ff;
   logic               rsp_fmiss_ff;

   logic [LIM_W-1:0] slot_limit;
   logic             load_in_range;

   logic [REL_W-1:0]   now_ext;
   logic [BUR_W-1:0]   work_cur;
   logic [RCNT_W-1:0]  count_cur;
   logic               release_now;
   logic               release_miss;
   logic [REL_W:0]     rel_sum;
   ptts_row_type       post_row;
   logic [REL_W-1:0]   key;
   logic               take;

   logic               fin_miss;
   logic [TIME_W:0]    miss_sum;
   logic [TIME_W-1:0]  miss_in;
   logic [TIME_W-1:0]  busy_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   ptts_row_type       wr_row;
   ptts_row_type       load_row;
   ptts_row_type       done_row;

   assign slot_limit = (LIM_W'(cfg.task_count) > LIM_W'(MAX_TASKS)) ?
                       LIM_W'(MAX_TASKS) : LIM_W'(cfg.task_count);
   assign load_in_range = (LIM_W'(req_index_ff) < LIM_W'(MAX_TASKS));

   assign status.req_is_tick = (req_opcode == OP_TICK);
   assign status.no_slots    = (slot_limit == '0);
   assign status.scan_last   = ((LIM_W'(rd_idx_ff) + LIM_W'(1)) == slot_limit);

   // Release and key evaluation of the slot read in the previous cycle.
   always_comb begin
      now_ext      = {2'b00, now_ff};
      work_cur     = rd_valid_ff ? rd_row_ff.work  : '0;
      count_cur    = rd_valid_ff ? rd_row_ff.count : '0;
      release_now  = rd_fire_ff && (rd_row_ff.rel_time == now_ext) &&
                     (count_cur < cfg.max_releases);
      release_miss = release_now && (work_cur != '0) && (rd_row_ff.due_time <= now_ext);
      rel_sum      = {1'b0, rd_row_ff.rel_time} + (REL_W + 1)'(rd_row_ff.period);

      post_row       = rd_row_ff;
      post_row.work  = work_cur;
      post_row.count = count_cur;
      if (release_now) begin
         post_row.work     = rd_row_ff.burst;
         post_row.count    = count_cur + RCNT_W'(1);
         post_row.rel_time = rel_sum[REL_W] ? '1 : rel_sum[REL_W-1:0];
         post_row.due_time = now_ext + REL_W'(rd_row_ff.period);
      end

      key  = (cfg.policy_mode == POLICY_RM) ? REL_W'(post_row.period) : post_row.due_time;
      take = rd_fire_ff && (post_row.work != '0) && (!found_ff || (key < best_key_ff));
   end

   // Finishing step of a tick.
   always_comb begin
      fin_miss = found_ff && (best_row_ff.work == BUR_W'(1)) &&
                 (now_ext >= best_row_ff.due_time);
      miss_sum = {1'b0, miss_ff} + (TIME_W + 1)'(rel_miss_ff) + (TIME_W + 1)'(fin_miss);
      miss_in  = miss_sum[TIME_W] ? '1 : miss_sum[TIME_W-1:0];
      busy_in  = (found_ff && (busy_ff != '1)) ? busy_ff + TIME_W'(1) : busy_ff;
   end

   // Memory write selection.
   always_comb begin
      load_row.period   = req_period_ff;
      load_row.burst    = req_burst_ff;
      load_row.rel_time = REL_W'(req_arrival_ff);
      load_row.due_time = REL_W'(req_arrival_ff) + REL_W'(req_period_ff);
      load_row.work     = '0;
      load_row.count    = '0;

      done_row      = best_row_ff;
      done_row.work = best_row_ff.work - BUR_W'(1);

      wr_en   = 1'b0;
      wr_addr = eval_idx_ff;
      wr_row  = post_row;
      if (cmd.load_write) begin
         wr_en   = load_in_range;
         wr_addr = IDX_W'(req_index_ff);
         wr_row  = load_row;
      end else if (cmd.finish) begin
         wr_en   = found_ff;
         wr_addr = best_idx_ff;
         wr_row  = done_row;
      end else if (release_now) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_row;
      end
      if (cmd.scan_read) begin
         rd_row_ff   <= mem_ff[rd_idx_ff];
         eval_idx_ff <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_index_ff   <= req_task_index;
         req_arrival_ff <= req_task_arrival;
         req_period_ff  <= req_task_period;
         req_burst_ff   <= req_task_burst;
      end
      if (cmd.scan_read) begin
         rd_valid_ff <= valid_ff[rd_idx_ff];
      end
      if (take) begin
         best_key_ff <= key;
         best_idx_ff <= eval_idx_ff;
         best_row_ff <= post_row;
      end
      if (cmd.finish) begin
         rsp_time_ff  <= now_ff;
         rsp_idle_ff  <= !found_ff;
         rsp_task_ff  <= found_ff ? SLOT_W'(best_idx_ff) : '0;
         rsp_rmiss_ff <= (32'(rel_miss_ff) > 32'd15) ? '1 : RMISS_W'(rel_miss_ff);
         rsp_fmiss_ff <= fin_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         rd_fire_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rel_miss_ff  <= '0;
         now_ff       <= '0;
         miss_ff      <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_fire_ff   <= cmd.scan_read;
         rsp_valid_ff <= cmd.finish;
         if (cmd.scan_clear) begin
            rd_idx_ff   <= '0;
            found_ff    <= 1'b0;
            rel_miss_ff <= '0;
         end else begin
            if (cmd.scan_read) begin
               rd_idx_ff <= rd_idx_ff + IDX_W'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
            if (release_miss) begin
               rel_miss_ff <= rel_miss_ff + CNT_W'(1);
            end
         end
         if (cmd.finish) begin
            now_ff  <= now_ff + TIME_W'(1);
            miss_ff <= miss_in;
            busy_ff <= busy_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tick_time      = rsp_time_ff;
   assign rsp_cpu_idle       = rsp_idle_ff;
   assign rsp_running_task   = rsp_task_ff;
   assign rsp_release_misses = rsp_rmiss_ff;
   assign rsp_finish_miss    = rsp_fmiss_ff;
   assign rsp_miss_total     = miss_ff;
   assign rsp_busy_ticks     = busy_ff;

endmodule

`default_nettype wire
